[hdl/zbr_pkg.sv]
`default_nettype none
package zbr_pkg;
    localparam int MaxWidth = 256;
    localparam int MaxHeight = 256;
    localparam int SubpixelBits = 4;
    localparam int StoreSize = MaxWidth * MaxHeight;
    localparam int AddrW = $clog2(StoreSize);
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam logic [23:0] FarDepth = 24'hFFFFFF;
    localparam logic [16:0] CountMax = 17'h1FFFF;
    localparam logic [1:0] ModeClear = 2'd0;
    localparam logic [1:0] ModeDraw = 2'd1;
    localparam logic [1:0] ModeRead = 2'd2;
    localparam logic CfgWidth = 1'b0;
    localparam logic CfgHeight = 1'b1;
endpackage
`default_nettype wire

[hdl/zbr_div.sv]
`default_nettype none
module zbr_div import zbr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [75:0] num,
    input  wire logic [37:0] den,
    output logic             done,
    output logic [75:0]      quo
);
    logic [75:0] q_reg;
    logic [38:0] r_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [38:0] trial;
    logic [38:0] sub;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_reg[37:0], q_reg[75]};
        sub   = trial - {1'b0, den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= !start && busy_reg && (cnt_reg == 7'd1);
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= num;
                r_reg    <= '0;
                cnt_reg  <= 7'd76;
            end else if (busy_reg) begin
                if (!sub[38]) begin
                    r_reg <= sub;
                    q_reg <= {q_reg[74:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[74:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end
    assign quo = q_reg;
endmodule
`default_nettype wire

[hdl/zbuffer_triangle_rasterizer_top.sv]
// clear: one entry a cycle over the whole store, then the result; read: RD0, RD1, then the
// result (no read when out of frame); draw: SETUP0 to SETUP3, then PIX0 to PIX4 and NEXT
// per bounding-box pixel, plus MUL0 to MUL2, the divide, DEPTH0, DEPTH1 per inside pixel
// one item at a time; the shared multipliers and serial divider set the rate
// synchronous active-low reset sets the state, frame size and write registers, then a
// pass writes far depth and black to every entry before the first transfer
`default_nettype none
module zbuffer_triangle_rasterizer_top import zbr_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_mode,
    input  wire logic signed [15:0] s_a_x,
    input  wire logic signed [15:0] s_a_y,
    input  wire logic [23:0]        s_a_depth,
    input  wire logic signed [15:0] s_b_x,
    input  wire logic signed [15:0] s_b_y,
    input  wire logic [23:0]        s_b_depth,
    input  wire logic signed [15:0] s_c_x,
    input  wire logic signed [15:0] s_c_y,
    input  wire logic [23:0]        s_c_depth,
    input  wire logic [23:0]        s_base_color,
    input  wire logic [8:0]         s_shade_level,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [23:0]             m_pixel_color,
    output logic [16:0]             m_pixels_written
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_CLEAR, ST_RD0, ST_RD1, ST_SETUP0, ST_SETUP1, ST_SETUP2,
        ST_SETUP3, ST_PIX0, ST_PIX1, ST_PIX2, ST_PIX3, ST_PIX4, ST_MUL0,
        ST_MUL1, ST_MUL2, ST_DIV, ST_DEPTH0, ST_DEPTH1, ST_NEXT, ST_OUT
    } state_t;

    state_t state_reg;
    logic       boot_reg;
    logic [8:0] width_reg, height_reg;
    logic [8:0] w_act, h_act;

    // stores
    logic [23:0] depth_mem [StoreSize];
    logic [23:0] color_mem [StoreSize];
    logic [AddrW-1:0] addr_reg;
    logic [23:0] depth_rd_reg, color_rd_reg;
    logic        we_reg;
    logic [23:0] wdepth_reg, wcolor_reg;

    // item registers
    logic signed [17:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [23:0] za_reg, zb_reg, zc_reg, color_reg;
    logic signed [37:0] denom_reg;
    logic signed [18:0] e1_reg, e2_reg, e3_reg, e4_reg; // by-cy, cx-bx, cy-ay, ax-cx
    logic signed [12:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [XW:0] x_reg;
    logic [YW:0] y_reg;
    logic signed [37:0] n1_reg, n2_reg, n3_reg, t_reg;
    logic [75:0] acc_reg;
    logic [16:0] count_reg;
    logic [23:0] out_color_reg;
    logic [16:0] out_count_reg;

    // shared multipliers
    logic signed [19:0] ma, mb;
    logic signed [39:0] mp;
    logic [37:0] ua;
    logic [23:0] ub;
    logic [61:0] up;
    assign mp = ma * mb;
    assign up = ua * ub;

    logic div_start, div_done;
    logic [75:0] div_quo;
    zbr_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(acc_reg + 76'(up)), .den(denom_reg[37] ? 38'(-denom_reg) : denom_reg),
        .done(div_done), .quo(div_quo)
    );

    logic [8:0] kclamp;
    logic signed [16:0] minx, maxx, miny, maxy;
    logic signed [19:0] pxd, pyd;
    logic [AddrW:0] row_base;

    function automatic logic signed [12:0] fl(input logic signed [16:0] c);
        fl = 13'(c >>> SubpixelBits);
    endfunction

    always_comb begin
        w_act = (width_reg == 9'd0) ? 9'd1 :
                (width_reg > 9'(MaxWidth)) ? 9'(MaxWidth) : width_reg;
        h_act = (height_reg == 9'd0) ? 9'd1 :
                (height_reg > 9'(MaxHeight)) ? 9'(MaxHeight) : height_reg;
        kclamp = (s_shade_level > 9'd256) ? 9'd256 : s_shade_level;
        minx = 17'(s_a_x); if (s_b_x < minx) minx = 17'(s_b_x);
        if (s_c_x < minx) minx = 17'(s_c_x);
        maxx = 17'(s_a_x); if (s_b_x > maxx) maxx = 17'(s_b_x);
        if (s_c_x > maxx) maxx = 17'(s_c_x);
        miny = 17'(s_a_y); if (s_b_y < miny) miny = 17'(s_b_y);
        if (s_c_y < miny) miny = 17'(s_c_y);
        maxy = 17'(s_a_y); if (s_b_y > maxy) maxy = 17'(s_b_y);
        if (s_c_y > maxy) maxy = 17'(s_c_y);
        pxd = 20'(({11'd0, x_reg} * 20'sd2 + 20'sd1) <<< SubpixelBits) - 20'(cx_reg);
        pyd = 20'(({11'd0, y_reg} * 20'sd2 + 20'sd1) <<< SubpixelBits) - 20'(cy_reg);
        ma = '0; mb = '0; ua = '0; ub = '0;
        case (state_reg)
            ST_SETUP1: begin ma = 20'(e1_reg); mb = 20'(e4_reg); end
            ST_SETUP2: begin ma = 20'(e2_reg); mb = 20'(ay_reg - cy_reg); end
            ST_PIX0:   begin ma = 20'(e1_reg); mb = pxd; end
            ST_PIX1:   begin ma = 20'(e2_reg); mb = pyd; end
            ST_PIX2:   begin ma = 20'(e3_reg); mb = pxd; end
            ST_PIX3:   begin ma = 20'(e4_reg); mb = pyd; end
            ST_MUL0:   begin ua = n1_reg; ub = za_reg; end
            ST_MUL1:   begin ua = n2_reg; ub = zb_reg; end
            ST_MUL2:   begin ua = n3_reg; ub = zc_reg; end
            default: ;
        endcase
        row_base = (AddrW+1)'(y_reg * w_act);
        div_start = (state_reg == ST_MUL2);
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_pixel_color = out_color_reg;
    assign m_pixels_written = out_count_reg;

    always_ff @(posedge aclk) begin
        depth_rd_reg <= depth_mem[addr_reg];
        color_rd_reg <= color_mem[addr_reg];
        if (we_reg) begin
            depth_mem[addr_reg] <= wdepth_reg;
            color_mem[addr_reg] <= wcolor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            boot_reg   <= 1'b1;
            addr_reg   <= '0;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            we_reg     <= 1'b1;
            wdepth_reg <= FarDepth;
            wcolor_reg <= '0;
        end else begin
            we_reg <= (state_reg == ST_IDLE && s_valid && s_mode == ModeClear)
                || (state_reg == ST_CLEAR && addr_reg != AddrW'(StoreSize - 1))
                || (state_reg == ST_DEPTH1 && wdepth_reg < depth_rd_reg);
            if (cfg_we) begin
                if (cfg_index == CfgWidth) width_reg <= cfg_data;
                else height_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    out_color_reg <= '0;
                    out_count_reg <= '0;
                    ax_reg <= 18'(s_a_x) <<< 1; ay_reg <= 18'(s_a_y) <<< 1;
                    bx_reg <= 18'(s_b_x) <<< 1; by_reg <= 18'(s_b_y) <<< 1;
                    cx_reg <= 18'(s_c_x) <<< 1; cy_reg <= 18'(s_c_y) <<< 1;
                    za_reg <= s_a_depth; zb_reg <= s_b_depth; zc_reg <= s_c_depth;
                    color_reg <= {8'(({8'd0, s_base_color[23:16]} * {7'd0, kclamp}) >> 8),
                                  8'(({8'd0, s_base_color[15:8]} * {7'd0, kclamp}) >> 8),
                                  8'(({8'd0, s_base_color[7:0]} * {7'd0, kclamp}) >> 8)};
                    x0_reg <= fl(minx);
                    x1_reg <= -fl(-maxx);
                    y0_reg <= fl(miny);
                    y1_reg <= -fl(-maxy);
                    count_reg <= '0;
                    case (s_mode)
                        ModeClear: begin
                            addr_reg <= '0; state_reg <= ST_CLEAR;
                            wdepth_reg <= FarDepth; wcolor_reg <= '0;
                        end
                        ModeDraw: state_reg <= ST_SETUP0;
                        ModeRead: begin
                            if (s_a_x >= 0 && s_a_y >= 0 && s_a_x < 16'(w_act)
                                && s_a_y < 16'(h_act)) begin
                                addr_reg <= AddrW'(s_a_y[YW-1:0] * w_act + s_a_x[XW-1:0]);
                                state_reg <= ST_RD0;
                            end else state_reg <= ST_OUT;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_CLEAR: begin
                    if (addr_reg == AddrW'(StoreSize - 1)) begin
                        state_reg <= boot_reg ? ST_IDLE : ST_OUT;
                        boot_reg <= 1'b0;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_RD0: state_reg <= ST_RD1;
                ST_RD1: begin out_color_reg <= color_rd_reg; state_reg <= ST_OUT; end
                ST_SETUP0: begin
                    e1_reg <= 19'(by_reg - cy_reg); e2_reg <= 19'(cx_reg - bx_reg);
                    e3_reg <= 19'(cy_reg - ay_reg); e4_reg <= 19'(ax_reg - cx_reg);
                    if (x0_reg < 0) x0_reg <= '0;
                    if (y0_reg < 0) y0_reg <= '0;
                    if (x1_reg > $signed({4'd0, w_act}) - 13'sd1)
                        x1_reg <= $signed({4'd0, w_act}) - 13'sd1;
                    if (y1_reg > $signed({4'd0, h_act}) - 13'sd1)
                        y1_reg <= $signed({4'd0, h_act}) - 13'sd1;
                    state_reg <= ST_SETUP1;
                end
                ST_SETUP1: begin t_reg <= 38'(mp); state_reg <= ST_SETUP2; end
                ST_SETUP2: begin
                    denom_reg <= t_reg + 38'(mp);
                    state_reg <= ST_SETUP3;
                end
                ST_SETUP3: begin
                    x_reg <= (XW+1)'(x0_reg); y_reg <= (YW+1)'(y0_reg);
                    if (denom_reg == 0 || x0_reg > x1_reg || y0_reg > y1_reg)
                        state_reg <= ST_OUT;
                    else state_reg <= ST_PIX0;
                end
                ST_PIX0: begin t_reg <= 38'(mp); state_reg <= ST_PIX1; end
                ST_PIX1: begin n1_reg <= t_reg + 38'(mp); state_reg <= ST_PIX2; end
                ST_PIX2: begin t_reg <= 38'(mp); state_reg <= ST_PIX3; end
                ST_PIX3: begin n2_reg <= t_reg + 38'(mp); state_reg <= ST_PIX4; end
                ST_PIX4: begin
                    addr_reg <= AddrW'(row_base + (AddrW+1)'(x_reg));
                    if (denom_reg < 0) begin
                        n1_reg <= -n1_reg; n2_reg <= -n2_reg;
                        n3_reg <= n1_reg + n2_reg - denom_reg;
                        if (n1_reg > 0 || n2_reg > 0 || n1_reg + n2_reg < denom_reg)
                            state_reg <= ST_NEXT;
                        else state_reg <= ST_MUL0;
                    end else begin
                        n3_reg <= denom_reg - n1_reg - n2_reg;
                        if (n1_reg < 0 || n2_reg < 0 || n1_reg + n2_reg > denom_reg)
                            state_reg <= ST_NEXT;
                        else state_reg <= ST_MUL0;
                    end
                end
                ST_MUL0: begin acc_reg <= 76'(up); state_reg <= ST_MUL1; end
                ST_MUL1: begin acc_reg <= acc_reg + 76'(up); state_reg <= ST_MUL2; end
                ST_MUL2: begin acc_reg <= acc_reg + 76'(up); state_reg <= ST_DIV; end
                ST_DIV: if (div_done) begin
                    wdepth_reg <= (div_quo > 76'(FarDepth)) ? FarDepth : div_quo[23:0];
                    state_reg <= ST_DEPTH0;
                end
                ST_DEPTH0: state_reg <= ST_DEPTH1;
                ST_DEPTH1: begin
                    if (wdepth_reg < depth_rd_reg) begin
                        wcolor_reg <= color_reg;
                        if (count_reg != CountMax) count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (13'(x_reg) < x1_reg) begin
                        x_reg <= x_reg + 1'b1; state_reg <= ST_PIX0;
                    end else if (13'(y_reg) < y1_reg) begin
                        x_reg <= (XW+1)'(x0_reg); y_reg <= y_reg + 1'b1;
                        state_reg <= ST_PIX0;
                    end else begin
                        out_count_reg <= count_reg; state_reg <= ST_OUT;
                    end
                end
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_ready_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_color_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pixels_written != 0 |-> m_pixel_color == 0)
        else $error("draw result carries color");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixels_written))
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

[sim/zbuffer_triangle_rasterizer_top_tb.sv]
`default_nettype none
module zbuffer_triangle_rasterizer_top_tb;
    import zbr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 400000;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] ax, ay, bx, by, cx, cy;
        logic [23:0]        az, bz, cz;
        logic [23:0]        color;
        logic [8:0]         shade;
        bit                 drain;
    } tri_item_t;

    typedef struct {
        logic [23:0] pixel;
        logic [16:0] written;
    } raster_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CfgWidth;
    logic [8:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    wire logic   s_ready;
    logic [1:0]  s_mode = ModeClear;
    logic signed [15:0] s_a_x = '0, s_a_y = '0, s_b_x = '0, s_b_y = '0;
    logic signed [15:0] s_c_x = '0, s_c_y = '0;
    logic [23:0] s_a_depth = '0, s_b_depth = '0, s_c_depth = '0;
    logic [23:0] s_base_color = '0;
    logic [8:0]  s_shade_level = '0;
    wire logic   m_valid;
    logic        m_ready = 1'b0;
    wire logic [23:0] m_pixel_color;
    wire logic [16:0] m_pixels_written;

    zbuffer_triangle_rasterizer_top dut (.*);

    bit [23:0] depth_mem [StoreSize];
    bit [23:0] color_mem [StoreSize];
    int unsigned width_reg = 256, height_reg = 256;

    tri_item_t   pending_items[$];
    raster_out_t expected_out[$];
    tri_item_t   cur;
    bit          idle_en = 1'b1;
    int          fail_cnt = 0;
    int          stall_cnt = 0;
    int          n_draw = 0, n_read = 0, n_clear = 0, n_other = 0;
    longint      total_written = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint active_dim(int unsigned raw, int unsigned lim);
        if (raw == 0) return 1;
        if (raw > lim) return lim;
        return raw;
    endfunction

    function automatic raster_out_t rasterize(tri_item_t it);
        raster_out_t r;
        longint w, h, ax, ay, bx, by, cx, cy, x0, x1, y0, y1, denom;
        longint px, py, n1, n2, n3, d, idx;
        longint unsigned z;
        int unsigned k, cr, cg, cb, cnt;
        logic [23:0] shaded;
        r.pixel = '0;
        r.written = '0;
        w = active_dim(width_reg, MaxWidth);
        h = active_dim(height_reg, MaxHeight);
        case (it.mode)
            ModeClear: begin
                for (int i = 0; i < StoreSize; i++) begin
                    depth_mem[i] = FarDepth;
                    color_mem[i] = '0;
                end
            end
            ModeRead: begin
                if (it.ax >= 0 && it.ay >= 0 && it.ax < w && it.ay < h) begin
                    idx = longint'(it.ay) * w + longint'(it.ax);
                    if (idx < StoreSize) r.pixel = color_mem[idx];
                end
            end
            ModeDraw: begin
                k = (it.shade > 256) ? 256 : it.shade;
                cr = (it.color[23:16] * k) >> 8;
                cg = (it.color[15:8] * k) >> 8;
                cb = (it.color[7:0] * k) >> 8;
                shaded = {cr[7:0], cg[7:0], cb[7:0]};
                ax = it.ax; ay = it.ay; bx = it.bx; by = it.by; cx = it.cx; cy = it.cy;
                x0 = (ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx)) >>> SubpixelBits;
                y0 = (ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy)) >>> SubpixelBits;
                x1 = -((-(ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx)))
                       >>> SubpixelBits);
                y1 = -((-(ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy)))
                       >>> SubpixelBits);
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > w - 1) x1 = w - 1;
                if (y1 > h - 1) y1 = h - 1;
                ax *= 2; ay *= 2; bx *= 2; by *= 2; cx *= 2; cy *= 2;
                denom = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
                cnt = 0;
                if (denom != 0) begin
                    for (longint y = y0; y <= y1; y++) begin
                        for (longint x = x0; x <= x1; x++) begin
                            px = (2 * x + 1) <<< SubpixelBits;
                            py = (2 * y + 1) <<< SubpixelBits;
                            n1 = (by - cy) * (px - cx) + (cx - bx) * (py - cy);
                            n2 = (cy - ay) * (px - cx) + (ax - cx) * (py - cy);
                            n3 = denom - n1 - n2;
                            d = denom;
                            if (d < 0) begin
                                d = -d; n1 = -n1; n2 = -n2; n3 = -n3;
                            end
                            if (n1 < 0 || n2 < 0 || n3 < 0) continue;
                            z = (longint'(n1) * longint'(it.az) + longint'(n2) * longint'(it.bz)
                                 + longint'(n3) * longint'(it.cz)) / d;
                            if (z > FarDepth) z = FarDepth;
                            idx = y * w + x;
                            if (idx >= StoreSize) continue;
                            if (z[23:0] < depth_mem[idx]) begin
                                depth_mem[idx] = z[23:0];
                                color_mem[idx] = shaded;
                                if (cnt < CountMax) cnt++;
                            end
                        end
                    end
                end
                r.written = cnt[16:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_out = {expected_out, rasterize(cur)};
                case (cur.mode)
                    ModeDraw:  n_draw++;
                    ModeRead:  n_read++;
                    ModeClear: n_clear++;
                    default:   n_other++;
                endcase
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && !(idle_en && $urandom_range(99) < 11)
                        && !(pending_items[0].drain && expected_out.size() > 0)) begin
                    cur = pending_items.pop_front();
                    s_mode <= cur.mode;
                    s_a_x <= cur.ax; s_a_y <= cur.ay; s_a_depth <= cur.az;
                    s_b_x <= cur.bx; s_b_y <= cur.by; s_b_depth <= cur.bz;
                    s_c_x <= cur.cx; s_c_y <= cur.cy; s_c_depth <= cur.cz;
                    s_base_color <= cur.color;
                    s_shade_level <= cur.shade;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        raster_out_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    fail_cnt++;
                end else begin
                    e = expected_out.pop_front();
                    if (m_pixel_color !== e.pixel) begin
                        $error("pixel_color: expected %h, actual %h", e.pixel, m_pixel_color);
                        fail_cnt++;
                    end
                    if (m_pixels_written !== e.written) begin
                        $error("pixels_written: expected %0d, actual %0d",
                               e.written, m_pixels_written);
                        fail_cnt++;
                    end
                    total_written += e.written;
                end
            end
            m_ready <= !(idle_en && $urandom_range(99) < 11);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= StallLimit) begin
                $display("timeout: no transfer for %0d cycles", StallLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() > 0 || s_valid || expected_out.size() > 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_screen(int unsigned wv, int unsigned hv);
        cfg_we <= 1'b1; cfg_index <= CfgWidth; cfg_data <= wv[8:0];
        @(posedge aclk);
        cfg_index <= CfgHeight; cfg_data <= hv[8:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_reg = 32'(wv[8:0]);
        height_reg = 32'(hv[8:0]);
    endtask

    function automatic tri_item_t blank_item(logic [1:0] m);
        tri_item_t it;
        it.mode = m;
        it.ax = '0; it.ay = '0; it.bx = '0; it.by = '0; it.cx = '0; it.cy = '0;
        it.az = '0; it.bz = '0; it.cz = '0;
        it.color = '0; it.shade = '0; it.drain = 1'b0;
        return it;
    endfunction

    function automatic tri_item_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                           int unsigned az, int unsigned bz, int unsigned cz,
                                           int unsigned col, int unsigned sh);
        tri_item_t it;
        it = blank_item(ModeDraw);
        it.ax = 16'(ax); it.ay = 16'(ay); it.bx = 16'(bx); it.by = 16'(by);
        it.cx = 16'(cx); it.cy = 16'(cy);
        it.az = 24'(az); it.bz = 24'(bz); it.cz = 24'(cz);
        it.color = 24'(col); it.shade = 9'(sh);
        return it;
    endfunction

    function automatic tri_item_t make_read(int col, int row);
        tri_item_t it;
        it = blank_item(ModeRead);
        it.ax = 16'(col); it.ay = 16'(row);
        it.az = 24'($urandom); it.color = 24'($urandom); it.shade = 9'($urandom);
        return it;
    endfunction

    function automatic tri_item_t rand_item(bit wild_ok);
        tri_item_t it;
        int unsigned r;
        int w, h;
        int mx, my;
        w = int'(active_dim(width_reg, MaxWidth));
        h = int'(active_dim(height_reg, MaxHeight));
        r = $urandom_range(99);
        if (r < 35) begin
            if ($urandom_range(9) == 0) it = make_read($urandom, $urandom);
            else it = make_read($urandom_range(w + 1) - 1, $urandom_range(h + 1) - 1);
        end else if (r < 40) begin
            it = blank_item(2'd3);
            it.ax = 16'($urandom); it.ay = 16'($urandom); it.bx = 16'($urandom);
            it.by = 16'($urandom); it.cx = 16'($urandom); it.cy = 16'($urandom);
            it.az = 24'($urandom); it.bz = 24'($urandom); it.cz = 24'($urandom);
            it.color = 24'($urandom); it.shade = 9'($urandom);
        end else if (wild_ok && r < 50) begin
            it = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            mx = $urandom_range(w * 16 - 1);
            my = $urandom_range(h * 16 - 1);
            it = make_tri(mx + $urandom_range(80) - 40, my + $urandom_range(80) - 40,
                          mx + $urandom_range(80) - 40, my + $urandom_range(80) - 40,
                          mx + $urandom_range(80) - 40, my + $urandom_range(80) - 40,
                          $urandom, $urandom, $urandom, $urandom, $urandom_range(300));
            if ($urandom_range(19) == 0) begin
                it.cx = 16'(2 * it.bx - it.ax);
                it.cy = 16'(2 * it.by - it.ay);
            end
        end
        it.drain = ($urandom_range(99) == 0);
        return it;
    endfunction

    task automatic run_phase(int unsigned wv, int unsigned hv, bit do_clear,
                             int n, bit wild_ok);
        wait_idle();
        set_screen(wv, hv);
        if (do_clear) pending_items = {pending_items, blank_item(ModeClear)};
        for (int i = 0; i < n; i++) pending_items = {pending_items, rand_item(wild_ok)};
    endtask

    initial begin
        tri_item_t it;
        for (int i = 0; i < StoreSize; i++) depth_mem[i] = FarDepth;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        pending_items = {pending_items, blank_item(ModeClear)};
        pending_items = {pending_items, make_tri(16, 16, 200, 24, 40, 180, 24'h100000,
                                                 24'h200000, 24'h300000, 24'hFF8040, 256)};
        pending_items = {pending_items, make_tri(8, 8, 160, 40, 24, 120, 24'h000000,
                                                 24'h000000, 24'h000000, 24'h123456, 511)};
        pending_items = {pending_items, make_tri(8, 8, 160, 40, 24, 120, 24'hFFFFFF,
                                                 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0)};
        pending_items = {pending_items, make_tri(0, 0, 64, 64, 128, 128, 24'h10, 24'h20,
                                                 24'h30, 24'hABCDEF, 128)};
        pending_items = {pending_items, make_tri(-32768, -32768, 32767, -32768, -32768,
                                                 -32000, 24'h0, 24'hFFFFFF, 24'h1,
                                                 24'hFFFFFF, 256)};
        pending_items = {pending_items, make_tri(32767, 32767, 32000, 32767, 32767, 32000,
                                                 24'h1, 24'h2, 24'h3, 24'h00FF00, 100)};
        pending_items = {pending_items, make_tri(4072, 4072, 4095, 4080, 4080, 4095,
                                                 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 257)};
        it = make_read(1, 1); it.drain = 1'b1;
        pending_items = {pending_items, it};
        pending_items = {pending_items, make_read(5, 3)};
        pending_items = {pending_items, make_read(0, 0)};
        pending_items = {pending_items, make_read(255, 255)};
        pending_items = {pending_items, make_read(-1, 0)};
        pending_items = {pending_items, make_read(0, -32768)};
        pending_items = {pending_items, make_read(256, 0)};
        pending_items = {pending_items, make_read(32767, 32767)};
        pending_items = {pending_items, make_read(0, 256)};
        it = blank_item(2'd3); it.ax = -16'sd1; it.ay = 16'sd32767; it.color = 24'hFFFFFF;
        pending_items = {pending_items, it};
        pending_items = {pending_items, make_read(4, 1)};

        run_phase(16, 16, 1'b1, 120, 1'b0);
        idle_en = 1'b0;
        run_phase(8, 4, 1'b0, 120, 1'b1);
        idle_en = 1'b1;
        run_phase(1, 1, 1'b0, 80, 1'b1);
        run_phase(0, 0, 1'b0, 40, 1'b1);
        run_phase(511, 300, 1'b1, 150, 1'b0);
        run_phase(256, 1, 1'b0, 100, 1'b0);
        run_phase(1, 256, 1'b0, 100, 1'b0);
        run_phase($urandom_range(2, 64), $urandom_range(2, 64), 1'b1, 150, 1'b0);
        run_phase(32, 24, 1'b0, 100, 1'b0);
        wait_idle();
        repeat (100) @(posedge aclk);

        $display("covered %0d draws, %0d reads, %0d clears, %0d unused-mode transfers",
                 n_draw, n_read, n_clear, n_other);
        $display("draws wrote %0d pixels across frame sizes from 1x1 to 256x256",
                 total_written);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
